@@ hw/rtl/opi_pkg.sv @@
`default_nettype none
package opi_pkg;

  localparam int TABLE_LEN = 24;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  typedef struct packed {
    logic [31:0]        stamp;
    logic signed [15:0] lin_vel;
    logic signed [23:0] ang_rate;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic [31:0]        heading;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic [31:0]        out_stamp;
  } out_item_t;

  // datapath commands
  typedef struct packed {
    logic load;       // capture input item
    logic first;      // record stamp only
    logic cordic_init;
    logic cordic_half; // angle source: half yaw
    logic cordic_step;
    logic trig_latch;  // round CORDIC result to Q1.15
    logic mul_vdt;
    logic mul_pos;
    logic acc_upd;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic cordic_done;
  } dp_stat_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
      5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
      5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
      5'd6: r = 32'd10679838;   5'd7: r = 32'd5340245;
      5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
      5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;     5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;       5'd21: r = 32'd326;
      5'd22: r = 32'd163;       5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] to_q15(input logic signed [33:0] q30);
    logic signed [34:0] t;
    logic signed [19:0] r;
    t = {q30[33], q30} + 35'sd16384;
    r = t[34:15];
    if (r > 20'sd32767) return 16'sd32767;
    if (r < -20'sd32768) return -16'sd32768;
    return r[15:0];
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/opi_if.sv @@
`default_nettype none
interface opi_in_if;
  logic valid;
  logic ready;
  opi_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface opi_out_if;
  logic valid;
  logic ready;
  opi_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/opi_ctrl.sv @@
`default_nettype none
module opi_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire opi_pkg::dp_stat_t stat,
  output opi_pkg::dp_cmd_t    cmd
);
  localparam logic [2:0] S_IDLE = 3'd0, S_COS1 = 3'd1, S_MUL = 3'd2, S_POS = 3'd3,
    S_ACC = 3'd4, S_COS2 = 3'd5, S_OUT = 3'd6, S_HALF = 3'd7;

  logic [2:0] state, state_next;
  logic started, started_next;
  logic ov, ov_next;
  logic launch;

  // the output register parts the sides: take a new beat while a result waits
  assign in_ready = (state == S_IDLE);
  assign out_valid = ov;

  always_comb begin
    cmd = '0;
    state_next = state;
    started_next = started;
    ov_next = ov && !out_ready;
    launch = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          if (!started) begin
            cmd.first = 1'b1;
            started_next = 1'b1;
          end else begin
            cmd.cordic_init = 1'b1;
            state_next = S_COS1;
          end
        end
      end
      S_COS1: begin
        cmd.cordic_step = 1'b1;
        if (stat.cordic_done) begin
          cmd.cordic_step = 1'b0;
          cmd.trig_latch = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_vdt = 1'b1;
        state_next = S_POS;
      end
      S_POS: begin
        cmd.mul_pos = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc_upd = 1'b1;
        state_next = S_HALF;
      end
      // start the half-yaw run once the new yaw is in place
      S_HALF: begin
        launch = 1'b1;
        state_next = S_COS2;
      end
      S_COS2: begin
        cmd.cordic_half = 1'b1;
        cmd.cordic_step = 1'b1;
        if (stat.cordic_done) begin
          cmd.cordic_step = 1'b0;
          cmd.trig_latch = 1'b1;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov || out_ready) begin
          cmd.out_load = 1'b1;
          ov_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (launch) begin
      cmd.cordic_init = 1'b1;
      cmd.cordic_half = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      started <= 1'b0;
      ov <= 1'b0;
    end else begin
      state <= state_next;
      started <= started_next;
      ov <= ov_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE) else $error("ready outside idle");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    ov && !out_ready |=> ov) else $error("result dropped");
  a_first_nores: assert property (@(posedge clk) disable iff (rst)
    cmd.first |=> state == S_IDLE) else $error("first sample started work");
`endif
endmodule
`default_nettype wire

@@ hw/rtl/opi_datapath.sv @@
`default_nettype none
module opi_datapath #(
  parameter int CORDIC_STEPS = 16,
  parameter int POS_BITS = 48
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire opi_pkg::in_item_t in_data,
  input  wire opi_pkg::dp_cmd_t  cmd,
  output opi_pkg::dp_stat_t      stat,
  output opi_pkg::out_item_t     out_data
);
  localparam int NSTEP = (CORDIC_STEPS < opi_pkg::TABLE_LEN) ? CORDIC_STEPS
                                                             : opi_pkg::TABLE_LEN;
  localparam logic signed [POS_BITS-1:0] PMAX = {1'b0, {(POS_BITS-1){1'b1}}};
  localparam logic signed [POS_BITS-1:0] PMIN = {1'b1, {(POS_BITS-1){1'b0}}};

  logic [31:0] last_stamp, cur_stamp, dt;
  logic signed [15:0] v;
  logic signed [23:0] w;
  logic signed [POS_BITS-1:0] acc_x, acc_y;
  logic [31:0] acc_yaw;

  // CORDIC
  logic signed [33:0] cx, cy;
  logic signed [33:0] cz;
  logic [4:0] step;
  logic flip;
  logic signed [15:0] tsin, tcos;

  logic [31:0] ang_src;
  logic signed [33:0] z0;
  always_comb begin
    ang_src = cmd.cordic_half ? {acc_yaw[16:0], 15'd0} : {acc_yaw[15:0], 16'd0};
    z0 = {{2{ang_src[31]}}, ang_src};
  end

  logic signed [33:0] ysh, xsh, atn;
  assign ysh = cy >>> step;
  assign xsh = cx >>> step;
  assign atn = {2'b00, opi_pkg::atan_turn(step)};
  assign stat.cordic_done = (step == 5'(NSTEP));

  always_ff @(posedge clk) begin
    if (cmd.cordic_init) begin
      cx <= opi_pkg::CORDIC_GAIN;
      cy <= '0;
      step <= '0;
      if (z0 > 34'sd1073741824) begin
        cz <= z0 - 34'sd2147483648; flip <= 1'b1;
      end else if (z0 < -34'sd1073741824) begin
        cz <= z0 + 34'sd2147483648; flip <= 1'b1;
      end else begin
        cz <= z0; flip <= 1'b0;
      end
    end else if (cmd.cordic_step) begin
      step <= step + 5'd1;
      if (!cz[33]) begin
        cx <= cx - ysh; cy <= cy + xsh; cz <= cz - atn;
      end else begin
        cx <= cx + ysh; cy <= cy - xsh; cz <= cz + atn;
      end
    end
    if (cmd.trig_latch) begin
      tsin <= opi_pkg::to_q15(flip ? -cy : cy);
      tcos <= opi_pkg::to_q15(flip ? -cx : cx);
    end
  end

  // products
  logic signed [48:0] vdt;
  logic signed [56:0] wdt;
  logic signed [64:0] px, py;

  always_ff @(posedge clk) begin
    if (cmd.mul_vdt) begin
      vdt <= 49'(v) * $signed({17'd0, dt});
      wdt <= 57'(w) * $signed({1'b0, dt});
    end
    if (cmd.mul_pos) begin
      px <= 65'(vdt) * 65'(tcos) + 65'sd16384;
      py <= 65'(vdt) * 65'(tsin) + 65'sd16384;
    end
  end

  function automatic logic signed [POS_BITS-1:0] sat_add(
    input logic signed [POS_BITS-1:0] a, input logic signed [49:0] d);
    logic signed [65:0] s;
    s = 66'(a) + 66'(d);
    if (s > 66'(PMAX)) return PMAX;
    if (s < 66'(PMIN)) return PMIN;
    return s[POS_BITS-1:0];
  endfunction

  logic signed [56:0] wdr;
  logic signed [49:0] dx, dy;
  assign wdr = wdt + 57'sd32768;
  assign dx = 50'(px >>> 15);
  assign dy = 50'(py >>> 15);

  always_ff @(posedge clk) begin
    if (rst) begin
      last_stamp <= '0;
      acc_x <= '0;
      acc_y <= '0;
      acc_yaw <= '0;
    end else begin
      if (cmd.load) last_stamp <= in_data.stamp;
      if (cmd.acc_upd) begin
        acc_x <= sat_add(acc_x, dx);
        acc_y <= sat_add(acc_y, dy);
        acc_yaw <= acc_yaw + wdr[47:16];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_stamp <= in_data.stamp;
      dt <= in_data.stamp - last_stamp;
      v <= in_data.lin_vel;
      w <= in_data.ang_rate;
    end
    if (cmd.out_load) begin
      out_data.pos_x <= 48'(acc_x);
      out_data.pos_y <= 48'(acc_y);
      out_data.heading <= acc_yaw;
      out_data.quat_z <= tsin;
      out_data.quat_w <= tcos;
      out_data.out_stamp <= cur_stamp;
    end
  end

`ifndef NO_ASSERTIONS
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.cordic_step |-> step < 5'(NSTEP)) else $error("cordic overrun");
  a_init_step: assert property (@(posedge clk) disable iff (rst)
    cmd.cordic_init |=> step == 5'd0) else $error("cordic init");
  a_acc_excl: assert property (@(posedge clk) disable iff (rst)
    cmd.acc_upd |-> !cmd.load) else $error("overlap");
`endif
endmodule
`default_nettype wire

@@ hw/rtl/odometry_pose_integrator.sv @@
// Odometry pose integrator.
// Input channel: samples (stamp, lin_vel, ang_rate) with valid/ready.
// Output channel: pose (pos_x, pos_y, heading, quat_z, quat_w, out_stamp).
// The first sample after reset only records its stamp; no result follows.
// Each later sample runs through the single shared CORDIC unit twice, once
// for the motion heading and once for the half-yaw quaternion, and its
// result is loaded once the output register is free. One sample is in
// work at a time, so a new beat is taken only after the last result has
// been loaded into the output register.
// The result sits in an output register; a new sample is taken while it
// waits, and its result holds back until the register drains.
// Reset (rst, synchronous) clears the pose, the yaw and the started flag.
// Position saturates at the signed POS_BITS range; the port shows 48 bits.
`default_nettype none
module odometry_pose_integrator #(
  parameter int CORDIC_STEPS = 16,
  parameter int POS_BITS = 48
) (
  input wire logic clk,
  input wire logic rst,
  opi_in_if.sink   samples,
  opi_out_if.source pose
);
  opi_pkg::dp_cmd_t  cmd;
  opi_pkg::dp_stat_t stat;

  opi_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(samples.valid), .in_ready(samples.ready),
    .out_valid(pose.valid), .out_ready(pose.ready),
    .stat(stat), .cmd(cmd)
  );

  opi_datapath #(.CORDIC_STEPS(CORDIC_STEPS), .POS_BITS(POS_BITS)) u_dp (
    .clk(clk), .rst(rst), .in_data(samples.data),
    .cmd(cmd), .stat(stat), .out_data(pose.data)
  );
endmodule
`default_nettype wire
